// ----- src/sbck_pkg.sv -----
// Shared types and constants for the stretch blit with colour key.
`default_nettype none

package sbck_pkg;

  localparam int PixW     = 32;
  localparam int CoordW   = 12;
  localparam int SizeW    = 13;
  localparam int StepW    = 29;
  localparam int AccW     = 28;
  localparam int FracBits = 16;
  localparam int RegIdxW  = 3;
  localparam int AddrW    = 5;

  // Register map, byte address is 4 * index
  typedef enum logic [RegIdxW-1:0] {
    REG_DST_WIDTH  = 3'd0,
    REG_DST_HEIGHT = 3'd1,
    REG_X_STEP     = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_CONTROL    = 3'd4,
    REG_KEY_LOW    = 3'd5,
    REG_KEY_HIGH   = 3'd6,
    REG_KEY_MASK   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_SRC  = 2'd1,
    KEY_DST  = 2'd2,
    KEY_RSVD = 2'd3
  } key_mode_e;

  typedef struct packed {
    logic [SizeW-1:0] dst_width;
    logic [SizeW-1:0] dst_height;
    logic [StepW-1:0] x_step;
    logic [StepW-1:0] y_step;
    logic [3:0]       control;
    logic [PixW-1:0]  key_low;
    logic [PixW-1:0]  key_high;
    logic [PixW-1:0]  key_mask;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    dst_width:  13'd1,
    dst_height: 13'd1,
    x_step:     29'd65536,
    y_step:     29'd65536,
    control:    4'd0,
    key_low:    32'hFFFF_FFFF,
    key_high:   32'h0000_0000,
    key_mask:   32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [CoordW-1:0] wr_x;
    logic [CoordW-1:0] wr_y;
    logic [CoordW-1:0] next_src_x;
    logic [CoordW-1:0] next_src_y;
    logic [CoordW-1:0] next_dst_x;
    logic [CoordW-1:0] next_dst_y;
    logic              last;
  } walk_t;

  // Mirrored coordinate when flip is set; wraps when a counter sits beyond a shrunk size
  function automatic logic [CoordW-1:0] mirror(logic [SizeW:0] c, logic [SizeW:0] size,
                                               logic flip);
    logic [SizeW:0] m;
    m = flip ? (size - (SizeW+1)'(1) - c) : c;
    return m[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/sbck_regs.sv -----
// APB configuration register file.
`default_nettype none

module sbck_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbck_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output sbck_pkg::cfg_t                   cfg_o
);

  sbck_pkg::cfg_t      cfg_q, cfg_d;
  sbck_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign idx    = sbck_pkg::reg_idx_e'(paddr[sbck_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sbck_pkg::REG_DST_WIDTH:  cfg_d.dst_width  = pwdata[sbck_pkg::SizeW-1:0];
        sbck_pkg::REG_DST_HEIGHT: cfg_d.dst_height = pwdata[sbck_pkg::SizeW-1:0];
        sbck_pkg::REG_X_STEP:     cfg_d.x_step     = pwdata[sbck_pkg::StepW-1:0];
        sbck_pkg::REG_Y_STEP:     cfg_d.y_step     = pwdata[sbck_pkg::StepW-1:0];
        sbck_pkg::REG_CONTROL:    cfg_d.control    = pwdata[3:0];
        sbck_pkg::REG_KEY_LOW:    cfg_d.key_low    = pwdata;
        sbck_pkg::REG_KEY_HIGH:   cfg_d.key_high   = pwdata;
        sbck_pkg::REG_KEY_MASK:   cfg_d.key_mask   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sbck_pkg::REG_DST_WIDTH:  prdata = 32'(cfg_q.dst_width);
      sbck_pkg::REG_DST_HEIGHT: prdata = 32'(cfg_q.dst_height);
      sbck_pkg::REG_X_STEP:     prdata = 32'(cfg_q.x_step);
      sbck_pkg::REG_Y_STEP:     prdata = 32'(cfg_q.y_step);
      sbck_pkg::REG_CONTROL:    prdata = 32'(cfg_q.control);
      sbck_pkg::REG_KEY_LOW:    prdata = cfg_q.key_low;
      sbck_pkg::REG_KEY_HIGH:   prdata = cfg_q.key_high;
      sbck_pkg::REG_KEY_MASK:   prdata = cfg_q.key_mask;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sbck_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/sbck_walk.sv -----
// Raster walk: pixel counters, 12.16 source accumulators and mirrored addresses.
`default_nettype none

module sbck_walk #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  sbck_pkg::cfg_t  cfg_i,
  output sbck_pkg::walk_t pos_o
);

  localparam int SzW = sbck_pkg::SizeW + 1;
  // Effective sizes never exceed 8191, the largest value the size registers hold
  localparam int CntW = (MAX_DIM > 8192) ? sbck_pkg::SizeW : $clog2(MAX_DIM);
  localparam logic [SzW-1:0] MaxDimC = (MAX_DIM > 8191) ? SzW'(8191) : SzW'(MAX_DIM);
  localparam int AccW = sbck_pkg::AccW;
  localparam int Fb   = sbck_pkg::FracBits;
  localparam int Cw   = sbck_pkg::CoordW;

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [AccW-1:0] xacc_q, xacc_d, yacc_q, yacc_d;
  logic [SzW-1:0]  w_eff, h_eff, col_p1, row_p1;
  logic            col_end, row_end, flip_x, flip_y;

  always_comb begin
    if (cfg_i.dst_width == '0) begin
      w_eff = SzW'(1);
    end else if ({1'b0, cfg_i.dst_width} > MaxDimC) begin
      w_eff = MaxDimC;
    end else begin
      w_eff = {1'b0, cfg_i.dst_width};
    end
    if (cfg_i.dst_height == '0) begin
      h_eff = SzW'(1);
    end else if ({1'b0, cfg_i.dst_height} > MaxDimC) begin
      h_eff = MaxDimC;
    end else begin
      h_eff = {1'b0, cfg_i.dst_height};
    end
  end

  assign flip_x  = cfg_i.control[2];
  assign flip_y  = cfg_i.control[3];
  assign col_p1  = SzW'(col_q) + SzW'(1);
  assign row_p1  = SzW'(row_q) + SzW'(1);
  assign col_end = (col_p1 >= w_eff);
  assign row_end = (row_p1 >= h_eff);

  always_comb begin
    col_d  = col_p1[CntW-1:0];
    row_d  = row_q;
    xacc_d = xacc_q + cfg_i.x_step[AccW-1:0];
    yacc_d = yacc_q;
    if (col_end) begin
      col_d  = '0;
      xacc_d = '0;
      if (row_end) begin
        row_d  = '0;
        yacc_d = '0;
      end else begin
        row_d  = row_p1[CntW-1:0];
        yacc_d = yacc_q + cfg_i.y_step[AccW-1:0];
      end
    end
  end

  always_comb begin
    pos_o.wr_x       = sbck_pkg::mirror(SzW'(col_q), w_eff, flip_x);
    pos_o.wr_y       = sbck_pkg::mirror(SzW'(row_q), h_eff, flip_y);
    pos_o.next_src_x = xacc_d[Fb+Cw-1:Fb];
    pos_o.next_src_y = yacc_d[Fb+Cw-1:Fb];
    pos_o.next_dst_x = sbck_pkg::mirror(SzW'(col_d), w_eff, flip_x);
    pos_o.next_dst_y = sbck_pkg::mirror(SzW'(row_d), h_eff, flip_y);
    pos_o.last       = col_end & row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      xacc_q <= '0;
      yacc_q <= '0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      xacc_q <= xacc_d;
      yacc_q <= yacc_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/stretch_blit_color_key.sv -----
// Stretch blit with colour key: top level with input and result stages.
// An accepted beat is registered in the input stage, then in the result stage; one pixel
// per cycle unless the output stalls. Walk counters and accumulators step once per beat.
// in_ready_o drops only while both stages hold data and the output is stalled.
// Reset (rst_ni low, asynchronous) empties both stages, returns the walk to pixel 0,0
// and loads every configuration register with its reset value.
`default_nettype none

module stretch_blit_color_key #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbck_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [31:0]                 src_pixel_i,
  input  wire logic [31:0]                 dst_pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             write_enable_o,
  output logic      [31:0]                 write_data_o,
  output logic      [11:0]                 write_x_o,
  output logic      [11:0]                 write_y_o,
  output logic      [11:0]                 next_src_x_o,
  output logic      [11:0]                 next_src_y_o,
  output logic      [11:0]                 next_dst_x_o,
  output logic      [11:0]                 next_dst_y_o,
  output logic                             last_o
);

  localparam logic [31:0] PixMask =
    (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PIXEL_BITS) - 64'd1);

  sbck_pkg::cfg_t    cfg;
  sbck_pkg::walk_t   pos;
  sbck_pkg::key_mode_e mode;

  logic        s1_v_q, s1_v_d, out_v_q, out_v_d;
  logic [31:0] s1_src_q, s1_dst_q;
  logic [31:0] src_m, dst_m, key_val;
  logic        in_key, we, s2_ready, s2_load, in_acc;

  logic        we_q;
  logic [31:0] data_q;
  sbck_pkg::walk_t pos_q;

  sbck_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbck_walk #(.MAX_DIM(MAX_DIM)) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s2_load),
    .cfg_i  (cfg),
    .pos_o  (pos)
  );

  assign s2_ready   = !out_v_q || out_ready_i;
  assign s2_load    = s1_v_q && s2_ready;
  assign in_ready_o = !s1_v_q || s2_ready;
  assign in_acc     = in_valid_i && in_ready_o;

  // Colour key on the staged beat
  assign src_m = s1_src_q & PixMask;
  assign dst_m = s1_dst_q & PixMask;
  assign mode  = sbck_pkg::key_mode_e'(cfg.control[1:0]);

  always_comb begin
    key_val = (mode == sbck_pkg::KEY_DST) ? dst_m : src_m;
    key_val = key_val & cfg.key_mask;
    in_key  = (key_val >= cfg.key_low) && (key_val <= cfg.key_high);
    case (mode)
      sbck_pkg::KEY_SRC: we = in_key;
      sbck_pkg::KEY_DST: we = in_key;
      default:           we = 1'b1;
    endcase
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc) begin
      s1_v_d = 1'b1;
    end else if (s2_load) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (s2_load) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_src_q <= src_pixel_i;
      s1_dst_q <= dst_pixel_i;
    end
    if (s2_load) begin
      we_q   <= we;
      data_q <= src_m;
      pos_q  <= pos;
    end
  end

  assign out_valid_o    = out_v_q;
  assign write_enable_o = we_q;
  assign write_data_o   = data_q;
  assign write_x_o      = pos_q.wr_x;
  assign write_y_o      = pos_q.wr_y;
  assign next_src_x_o   = pos_q.next_src_x;
  assign next_src_y_o   = pos_q.next_src_y;
  assign next_dst_x_o   = pos_q.next_dst_x;
  assign next_dst_y_o   = pos_q.next_dst_y;
  assign last_o         = pos_q.last;

endmodule

`default_nettype wire

// ----- src/sbck_checker.sv -----
// Port-level checks for the stretch blit, bound to the top level.
`default_nettype none

module sbck_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        write_enable_o,
  input wire logic [31:0] write_data_o,
  input wire logic [11:0] write_x_o,
  input wire logic [11:0] next_src_x_o,
  input wire logic [11:0] next_src_y_o,
  input wire logic        last_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(write_data_o) && $stable(write_x_o)
      && $stable(write_enable_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // Walk restart rewinds the source accumulators
  a_last_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> next_src_x_o == 12'd0 && next_src_y_o == 12'd0)
    else $error("last beat without source restart");

  // Reset leaves no result beat pending
  a_no_spurious: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat straight out of reset");

endmodule

bind stretch_blit_color_key sbck_checker u_sbck_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .write_enable_o (write_enable_o),
  .write_data_o   (write_data_o),
  .write_x_o      (write_x_o),
  .next_src_x_o   (next_src_x_o),
  .next_src_y_o   (next_src_y_o),
  .last_o         (last_o)
);

`default_nettype wire
